// ===== rtl/core/ssrs_pkg.sv =====
`timescale 1ns / 1ps

package ssrs_pkg;

  // Field widths
  localparam int KIND_W   = 2;
  localparam int MOTOR_W  = 4;
  localparam int ACTION_W = 3;
  localparam int PULSE_W  = 24;
  localparam int POS_W    = 32;
  localparam int TIME_W   = 32;
  localparam int MS_W     = 16;
  localparam int COUNT_W  = 5;
  localparam int PHASE_W  = 2;
  localparam int MODE_W   = 2;

  // Motor ids reachable through the motor field
  localparam int MOTOR_IDS = 2 ** MOTOR_W;
  localparam int MOTORS_DEFAULT = 16;

  // Config port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_GUARD_ON       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSED         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_COUNT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COOL_MS        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_TIMEOUT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_DISTANCE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK_PULSES    = 3'd6;

  // Register reset values
  localparam logic               RST_GUARD_ON       = 1'b1;
  localparam logic               RST_PAUSED         = 1'b0;
  localparam logic [COUNT_W-1:0] RST_MOTOR_COUNT    = 5'd0;
  localparam logic [MS_W-1:0]    RST_COOL_MS        = 16'd3000;
  localparam logic [MS_W-1:0]    RST_MOVE_TIMEOUT   = 16'd10000;
  localparam logic [MS_W-1:0]    RST_START_DISTANCE = 16'd1000;
  localparam logic [PULSE_W-1:0] RST_BACK_PULSES    = 24'd3200;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REPORT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DIR    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ACK    = 2'd3;

  // Actions
  localparam logic [ACTION_W-1:0] ACT_STOP    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_RELEASE = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_ENABLE  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_REVERSE = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CLEAR   = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_FAILED  = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_TIMEOUT = 3'd6;

  // Recovery phases
  localparam logic [PHASE_W-1:0] PH_IDLE    = 2'd0;
  localparam logic [PHASE_W-1:0] PH_CAPTURE = 2'd1;
  localparam logic [PHASE_W-1:0] PH_ACK     = 2'd2;
  localparam logic [PHASE_W-1:0] PH_MOVING  = 2'd3;

  // How many words a decision produces
  localparam logic [MODE_W-1:0] EMIT_NONE   = 2'd0;
  localparam logic [MODE_W-1:0] EMIT_ONE    = 2'd1;
  localparam logic [MODE_W-1:0] EMIT_TRIPLE = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [MOTOR_W-1:0]      motor;
    logic                    clockwise;
    logic                    read_ok;
    logic                    stalled;
    logic                    home_read_ok;
    logic                    homing_active;
    logic signed [POS_W-1:0] position;
    logic                    in_position;
    logic                    move_ok;
  } item_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [MOTOR_W-1:0]  target_motor;
    logic                direction;
    logic [PULSE_W-1:0]  pulses;
    logic                last;
  } result_t;

  typedef struct packed {
    logic               guard_on;
    logic               paused;
    logic [COUNT_W-1:0] motor_count;
    logic [MS_W-1:0]    cool_ms;
    logic [MS_W-1:0]    move_timeout_ms;
    logic [MS_W-1:0]    start_distance;
    logic [PULSE_W-1:0] back_pulses;
  } ssrs_cfg_t;

  // Decision handed from the engine to the word sequencer
  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [ACTION_W-1:0] action;
    logic [MOTOR_W-1:0]  motor;
    logic                direction;
    logic [PULSE_W-1:0]  pulses;
  } ssrs_desc_t;

endpackage

// ===== rtl/core/ssrs_cfg_regs.sv =====
`timescale 1ns / 1ps

module ssrs_cfg_regs
  import ssrs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  we,
  input  logic [CFG_IDX_W-1:0]  index,
  input  logic [CFG_DATA_W-1:0] data,
  output ssrs_cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.guard_on        <= RST_GUARD_ON;
      cfg.paused          <= RST_PAUSED;
      cfg.motor_count     <= RST_MOTOR_COUNT;
      cfg.cool_ms         <= RST_COOL_MS;
      cfg.move_timeout_ms <= RST_MOVE_TIMEOUT;
      cfg.start_distance  <= RST_START_DISTANCE;
      cfg.back_pulses     <= RST_BACK_PULSES;
    end else if (we) begin
      unique case (index)
        CFG_GUARD_ON:       cfg.guard_on        <= data[0];
        CFG_PAUSED:         cfg.paused          <= data[0];
        CFG_MOTOR_COUNT:    cfg.motor_count     <= data[COUNT_W-1:0];
        CFG_COOL_MS:        cfg.cool_ms         <= data[MS_W-1:0];
        CFG_MOVE_TIMEOUT:   cfg.move_timeout_ms <= data[MS_W-1:0];
        CFG_START_DISTANCE: cfg.start_distance  <= data[MS_W-1:0];
        CFG_BACK_PULSES:    cfg.back_pulses     <= data[PULSE_W-1:0];
        default: ;  // unused index, dropped
      endcase
    end
  end

endmodule

// ===== rtl/core/ssrs_engine.sv =====
`timescale 1ns / 1ps

module ssrs_engine
  import ssrs_pkg::*;
#(
  parameter int MOTORS = MOTORS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  item_t      item,
  input  ssrs_cfg_t  cfg,
  output ssrs_desc_t desc
);

  // Only ids the motor field can carry ever get a slot
  localparam int SLOTS = (MOTORS < MOTOR_IDS) ? MOTORS : MOTOR_IDS;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CMP_W = $clog2(MOTOR_IDS * 4 + 1);

  logic [TIME_W-1:0]  time_ms, time_ms_next;
  logic [PHASE_W-1:0] phase, phase_next;
  logic [MOTOR_W-1:0] active_motor, active_motor_next;
  logic [POS_W-1:0]   start_position, start_position_next;
  logic               motion_seen, motion_seen_next;
  logic [TIME_W-1:0]  deadline, deadline_next;

  logic [SLOTS-1:0]  dir_cw;
  logic [SLOTS-1:0]  recovered;
  logic [TIME_W-1:0] rec_time [SLOTS];

  logic              dir_we;
  logic              rec_we;
  logic [IDX_W-1:0]  slot;
  logic [IDX_W-1:0]  act_slot;
  logic              in_range;
  logic              watched;
  logic              cool;
  logic              stall_hit;
  logic [TIME_W-1:0] time_inc;
  logic [TIME_W-1:0] since_rec;
  logic [TIME_W-1:0] tick_gap;
  logic [TIME_W-1:0] now_gap;
  logic              tick_expired;
  logic              now_expired;
  logic [POS_W-1:0]  delta;
  logic [POS_W-1:0]  sd_wide;
  logic              far;

  assign slot     = item.motor[IDX_W-1:0];
  assign act_slot = active_motor[IDX_W-1:0];
  assign in_range = CMP_W'(item.motor) < CMP_W'(MOTORS);
  assign watched  = in_range && ({1'b0, item.motor} < cfg.motor_count);

  assign since_rec = time_ms - rec_time[slot];
  assign cool      = recovered[slot] && (since_rec < TIME_W'(cfg.cool_ms));
  assign stall_hit = item.read_ok && item.stalled && !(item.home_read_ok && item.homing_active);

  // Deadline is reached once time_ms - deadline is non-negative (mod 2^32)
  assign time_inc     = time_ms + TIME_W'(1);
  assign tick_gap     = time_inc - deadline;
  assign now_gap      = time_ms - deadline;
  assign tick_expired = !tick_gap[TIME_W-1];
  assign now_expired  = !now_gap[TIME_W-1];

  // |delta| > sd without a negate: a negative delta qualifies when delta <= ~sd
  assign delta   = $unsigned(item.position) - start_position;
  assign sd_wide = POS_W'(cfg.start_distance);
  assign far     = delta[POS_W-1] ? (delta <= ~sd_wide) : (delta > sd_wide);

  always_comb begin
    time_ms_next        = time_ms;
    phase_next          = phase;
    active_motor_next   = active_motor;
    start_position_next = start_position;
    motion_seen_next    = motion_seen;
    deadline_next       = deadline;
    dir_we              = 1'b0;
    rec_we              = 1'b0;
    desc.mode           = EMIT_NONE;
    desc.action         = ACT_STOP;
    desc.motor          = active_motor;
    desc.direction      = 1'b0;
    desc.pulses         = '0;

    unique case (item.kind)
      KIND_TICK: begin
        time_ms_next = time_inc;
        if (phase == PH_MOVING && tick_expired) begin
          desc.mode   = EMIT_ONE;
          desc.action = ACT_TIMEOUT;
          phase_next  = PH_IDLE;
        end
      end
      KIND_DIR: begin
        dir_we = in_range;
      end
      KIND_ACK: begin
        if (phase == PH_ACK) begin
          if (!item.move_ok) begin
            desc.mode   = EMIT_ONE;
            desc.action = ACT_FAILED;
            phase_next  = PH_IDLE;
          end else begin
            deadline_next    = time_ms + TIME_W'(cfg.move_timeout_ms);
            motion_seen_next = 1'b0;
            phase_next       = PH_MOVING;
            if (cfg.move_timeout_ms == '0) begin
              desc.mode   = EMIT_ONE;
              desc.action = ACT_TIMEOUT;
              phase_next  = PH_IDLE;
            end
          end
        end
      end
      KIND_REPORT: begin
        if (phase == PH_IDLE) begin
          if (cfg.guard_on && !cfg.paused && watched && !cool && stall_hit) begin
            rec_we            = 1'b1;
            active_motor_next = item.motor;
            desc.mode         = EMIT_TRIPLE;
            desc.motor        = item.motor;
            phase_next        = PH_CAPTURE;
          end
        end else if (item.motor == active_motor) begin
          if (phase == PH_CAPTURE) begin
            // failed read captures zero
            start_position_next = item.read_ok ? $unsigned(item.position) : '0;
            desc.mode           = EMIT_ONE;
            desc.action         = ACT_REVERSE;
            desc.direction      = !dir_cw[act_slot];
            desc.pulses         = cfg.back_pulses;
            phase_next          = PH_ACK;
          end else if (phase == PH_MOVING) begin
            if (now_expired) begin
              desc.mode   = EMIT_ONE;
              desc.action = ACT_TIMEOUT;
              phase_next  = PH_IDLE;
            end else if (item.read_ok) begin
              if (!motion_seen) begin
                motion_seen_next = far;
              end else if (item.in_position) begin
                desc.mode   = EMIT_ONE;
                desc.action = ACT_CLEAR;
                phase_next  = PH_IDLE;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_ms        <= '0;
      phase          <= PH_IDLE;
      active_motor   <= '0;
      start_position <= '0;
      motion_seen    <= 1'b0;
      deadline       <= '0;
      dir_cw         <= '1;
      recovered      <= '0;
    end else if (go) begin
      time_ms        <= time_ms_next;
      phase          <= phase_next;
      active_motor   <= active_motor_next;
      start_position <= start_position_next;
      motion_seen    <= motion_seen_next;
      deadline       <= deadline_next;
      if (dir_we) begin
        dir_cw[slot] <= item.clockwise;
      end
      if (rec_we) begin
        recovered[slot] <= 1'b1;
      end
    end
  end

  // Recovery stamp is only read behind its recovered bit
  always_ff @(posedge clk) begin
    if (go && rec_we) begin
      rec_time[slot] <= time_ms;
    end
  end

  a_idle_exit: assert property (@(posedge clk) disable iff (rst)
    (go && phase == PH_IDLE) |=> (phase == PH_IDLE || phase == PH_CAPTURE))
    else $error("recovery left idle into a phase other than capture");

  a_triple_idle: assert property (@(posedge clk) disable iff (rst)
    (desc.mode == EMIT_TRIPLE) |-> (phase == PH_IDLE))
    else $error("stop/release/enable burst outside idle");

  a_tick_time: assert property (@(posedge clk) disable iff (rst)
    (go && item.kind == KIND_TICK) |=> (time_ms == $past(time_ms) + TIME_W'(1)))
    else $error("tick did not advance time_ms by one");

endmodule

// ===== rtl/core/ssrs_emit.sv =====
`timescale 1ns / 1ps

module ssrs_emit
  import ssrs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  ssrs_desc_t desc,
  output logic       free,
  output logic       result_valid,
  input  logic       result_stall,
  output result_t    result
);

  // Words still owed after the one on display (burst only)
  logic [1:0] rem, rem_next;
  logic       result_valid_next;
  result_t    word_next;
  logic       taken;

  assign taken = result_valid && !result_stall;
  assign free  = !result_valid || (taken && rem == 2'd0);

  always_comb begin
    rem_next          = rem;
    result_valid_next = result_valid;
    word_next         = result;
    if (load) begin
      result_valid_next = 1'b1;
      word_next.target_motor = desc.motor;
      if (desc.mode == EMIT_TRIPLE) begin
        word_next.action    = ACT_STOP;
        word_next.direction = 1'b0;
        word_next.pulses    = '0;
        word_next.last      = 1'b0;
        rem_next            = 2'd2;
      end else begin
        word_next.action    = desc.action;
        word_next.direction = desc.direction;
        word_next.pulses    = desc.pulses;
        word_next.last      = 1'b1;
        rem_next            = 2'd0;
      end
    end else if (taken) begin
      if (rem != 2'd0) begin
        word_next.action = (rem == 2'd2) ? ACT_RELEASE : ACT_ENABLE;
        word_next.last   = (rem == 2'd1);
        rem_next         = rem - 2'd1;
      end else begin
        result_valid_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      rem          <= 2'd0;
    end else begin
      result_valid <= result_valid_next;
      rem          <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= word_next;
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("decision loaded while a word was still owed");

  a_last_rem: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.last == (rem == 2'd0)))
    else $error("last flag out of step with burst count");

  a_burst_motor: assert property (@(posedge clk) disable iff (rst)
    (taken && !result.last) |=>
      (result_valid && result.target_motor == $past(result.target_motor)))
    else $error("burst broke or switched motor");

endmodule

// ===== rtl/core/stepper_stall_recovery_supervisor_core.sv =====
`timescale 1ns / 1ps

// Channel  | handshake                  | payload
// ---------+----------------------------+-----------------------------
// item     | item_valid / item_stall    | item   (item_t)
// result   | result_valid / result_stall| result (result_t)
// cfg      | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// An accepted word waits in the item register, where the engine decides it
// and updates all motor state as it leaves; its first result word shows
// on the next cycle.
// One item per cycle; an item that yields words waits in the item register
// until the previous item's final word has been taken from the word
// sequencer. A stall start yields three words: stop, release, enable.
// rst is synchronous: phase idle, time zero, all motors clockwise, no motor
// in cooldown, registers at their defaults. cfg_ready is always high.

module stepper_stall_recovery_supervisor_core
  import ssrs_pkg::*;
#(
  parameter int MOTORS = MOTORS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ssrs_cfg_t  cfg;
  ssrs_desc_t desc;
  item_t      stage;
  logic       stage_valid;
  logic       go;
  logic       load;
  logic       free;

  assign cfg_ready = 1'b1;

  ssrs_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_valid),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  // Item register: a held word leaves only when its words have room
  assign go         = stage_valid && (desc.mode == EMIT_NONE || free);
  assign load       = go && desc.mode != EMIT_NONE;
  assign item_stall = stage_valid && !go;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!item_stall) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      stage <= item;
    end
  end

  ssrs_engine #(
    .MOTORS (MOTORS)
  ) u_engine (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .item (stage),
    .cfg  (cfg),
    .desc (desc)
  );

  // Word sequencer doubles as the output register
  ssrs_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .desc         (desc),
    .free         (free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
